FILE: sv/tidp_pkg.sv
// shared types and constants for the transaction id pool
// no dependencies; imported by tidp_alu, the top level and the testbench
package tidp_pkg;

    localparam int ID_SPACE_DEF  = 1024;
    localparam int TIME_BITS_DEF = 48;

    // fixed field widths
    localparam int ID_PORT_W = 10;
    localparam int CAP_W     = 11;
    localparam int INIT_W    = 16;
    localparam int GUARD_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int BIT_W     = $clog2(INIT_W);

    localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(1024);
    localparam logic [INIT_W-1:0] INIT_RESET  = '0;
    localparam logic [GUARD_W-1:0] GUARD_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_INITIAL  = 2'd1,
        CFG_GUARD    = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_UNAVAIL = 2'd0,
        ST_FREE    = 2'd1,
        ST_PENDING = 2'd2,
        ST_RETIRED = 2'd3
    } id_status_t;

    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        S_MOD,
        S_FILL,
        S_IDLE,
        S_RCL_RD,
        S_RCL_CMP,
        S_POP,
        S_POP_WR,
        S_REL_RD,
        S_REL_CHK,
        S_OUT
    } state_t;

endpackage

FILE: sv/tidp_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module tidp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/tidp_alu.sv
// shared add / subtract unit: remainder steps, due-time compare, reuse time
// depends on tidp_pkg
module tidp_alu
    import tidp_pkg::*;
#(
    parameter int W = 48
) (
    input  alu_op_t      op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W:0]   sum
);

    logic [W:0] b_ext;

    // subtract as a + ~b + 1, top bit set means a >= b
    always_comb
    begin
        case (op)
            ALU_ADD: b_ext = {1'b0, b};
            ALU_SUB: b_ext = {1'b0, ~b};
            default: b_ext = {1'b0, b};
        endcase
        sum = {1'b0, a} + b_ext + ((op == ALU_SUB) ? (W+1)'(1) : (W+1)'(0));
    end

endmodule

FILE: sv/transaction_id_pool_with_quarantine.sv
// transaction id pool with reuse quarantine; depends on tidp_pkg, tidp_ram, tidp_alu
// release walks S_REL_RD, S_REL_CHK (skipped for an id out of range) and S_OUT;
// allocate loops S_RCL_RD / S_RCL_CMP while due ids remain, then walks S_POP,
// S_POP_WR (skipped on an empty pool) and S_OUT. a new word is taken only in S_IDLE.
// reset and any pool_capacity or initial_id write start a rebuild pass (S_MOD remainder
// steps, then S_FILL over every id) during which no word is accepted.
module transaction_id_pool_with_quarantine
    import tidp_pkg::*;
#(
    parameter int ID_SPACE  = ID_SPACE_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GUARD_W-1:0]   cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [ID_PORT_W-1:0] release_id_value,
    input  logic                 quarantine,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 granted,
    output logic [ID_PORT_W-1:0] granted_id,
    output logic                 fault
);

    localparam int IW = $clog2(ID_SPACE);
    localparam int CW = $clog2(ID_SPACE + 1);
    localparam int KW = (CW > ID_PORT_W) ? CW : ID_PORT_W;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int UW = (TIME_BITS > GUARD_W) ? TIME_BITS : GUARD_W;
    localparam int RW = TIME_BITS + IW;
    localparam logic [IW-1:0] ID_LAST = IW'(ID_SPACE - 1);

    // configuration
    logic [CAP_W-1:0]   cap_reg;
    logic [INIT_W-1:0]  init_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic               geom_write;
    logic [CW-1:0]      cap_used;

    // sequencer and pool state
    state_t             state_reg, state_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [IW-1:0]      fill_reg, fill_next;
    logic [IW-1:0]      val_reg, val_next;
    logic [CW-1:0]      fc_reg, fc_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      rcnt_reg, rcnt_next;

    // captured word
    op_t                op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [ID_PORT_W-1:0] rel_reg;
    logic               quar_reg;

    // pending result and output register
    logic               res_grant_reg, res_grant_next;
    logic [IW-1:0]      res_id_reg, res_id_next;
    logic               res_fault_reg, res_fault_next;
    logic               out_valid_reg;
    logic               out_grant_reg;
    logic [ID_PORT_W-1:0] out_id_reg;
    logic               out_fault_reg;
    logic               out_load;
    logic [KW-1:0]      res_id_ext;

    // rams
    logic               st_we;
    logic [IW-1:0]      st_waddr, st_raddr;
    logic [1:0]         st_wdata, st_rdata;
    logic               fs_we;
    logic [IW-1:0]      fs_waddr, fs_raddr;
    logic [IW-1:0]      fs_wdata, fs_rdata;
    logic               rt_we;
    logic [RW-1:0]      rt_wdata, rt_rdata;

    // shared unit
    alu_op_t            alu_op;
    logic [UW-1:0]      alu_a, alu_b;
    logic [UW:0]        alu_sum;
    logic               alu_carry;

    // derived conditions
    logic [CW:0]        mod_t;
    logic [CW-1:0]      rem_new;
    logic [KW-1:0]      rel_ext;
    logic               rel_oob;
    logic               rel_pending;
    logic               rel_retire;
    logic               sat;
    logic [TIME_BITS-1:0] reuse_t;
    logic [TIME_BITS-1:0] rt_time;
    logic [IW-1:0]      rt_id;
    logic               in_fire;
    logic [LW-1:0]      cap_ext;

    assign geom_write = cfg_write && ((cfg_index == CFG_CAPACITY) ||
                                      (cfg_index == CFG_INITIAL));
    assign cap_ext    = LW'(cap_reg);
    assign cap_used   = (cap_reg == '0) ? CW'(1) :
                        ((cap_ext > LW'(ID_SPACE)) ? CW'(ID_SPACE) : CW'(cap_reg));

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;

    assign mod_t      = {rem_reg, init_reg[bit_reg]};
    assign alu_carry  = alu_sum[UW];
    assign rem_new    = alu_carry ? alu_sum[CW-1:0] : mod_t[CW-1:0];

    assign rel_ext     = KW'(rel_reg);
    assign rel_oob     = (rel_ext >= KW'(cap_used));
    assign rel_pending = (st_rdata == ST_PENDING);
    assign rel_retire  = quar_reg && (guard_reg != '0);

    assign sat      = (alu_sum[UW:TIME_BITS] != '0);
    assign reuse_t  = sat ? '1 : alu_sum[TIME_BITS-1:0];
    assign rt_id    = rt_rdata[IW-1:0];
    assign rt_time  = rt_rdata[RW-1:IW];

    assign st_raddr = rel_ext[IW-1:0];
    assign fs_raddr = IW'(fc_reg - CW'(1));
    assign rt_wdata = {reuse_t, IW'(rel_reg)};

    tidp_ram #(.WIDTH(2), .DEPTH(ID_SPACE)) u_status (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tidp_ram #(.WIDTH(IW), .DEPTH(ID_SPACE)) u_free_stack (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    tidp_ram #(.WIDTH(RW), .DEPTH(ID_SPACE)) u_retired (
        .clk   (clk),
        .we    (rt_we),
        .waddr (tail_reg),
        .wdata (rt_wdata),
        .raddr (head_reg),
        .rdata (rt_rdata)
    );

    tidp_alu #(.W(UW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_MOD:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (fill_reg == ID_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (operation == OP_ALLOC) ? S_RCL_RD : S_REL_RD;
                end
            end
            S_RCL_RD:  state_next = (rcnt_reg == '0) ? S_POP : S_RCL_CMP;
            S_RCL_CMP: state_next = alu_carry ? S_RCL_RD : S_POP;
            S_POP:     state_next = (fc_reg == '0) ? S_OUT : S_POP_WR;
            S_POP_WR:  state_next = S_OUT;
            S_REL_RD:  state_next = rel_oob ? S_OUT : S_REL_CHK;
            S_REL_CHK: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_MOD;
        endcase
        if (geom_write)
        begin
            state_next = S_MOD;
        end
    end

    // datapath controls
    always_comb
    begin
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        fill_next      = fill_reg;
        val_next       = val_reg;
        fc_next        = fc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rcnt_next      = rcnt_reg;
        res_grant_next = res_grant_reg;
        res_id_next    = res_id_reg;
        res_fault_next = res_fault_reg;
        out_load       = 1'b0;
        st_we          = 1'b0;
        st_waddr       = fill_reg;
        st_wdata       = ST_FREE;
        fs_we          = 1'b0;
        fs_waddr       = fc_reg[IW-1:0];
        fs_wdata       = fill_reg;
        rt_we          = 1'b0;
        alu_op         = ALU_SUB;
        alu_a          = UW'(now_reg);
        alu_b          = UW'(rt_time);

        case (state_reg)
            S_MOD:
            begin
                // one restoring remainder step per cycle
                alu_a    = UW'(mod_t);
                alu_b    = UW'(cap_used);
                rem_next = rem_new;
                bit_next = bit_reg - BIT_W'(1);
                // bottom of the stack holds (first + cap - 1) mod cap, so first is on top
                val_next = (rem_new == '0) ? IW'(cap_used - CW'(1)) :
                                             IW'(rem_new - CW'(1));
                fill_next = '0;
            end
            S_FILL:
            begin
                st_we     = 1'b1;
                st_waddr  = fill_reg;
                st_wdata  = (CW'(fill_reg) < cap_used) ? ST_FREE : ST_UNAVAIL;
                fs_we     = 1'b1;
                fs_waddr  = fill_reg;
                fs_wdata  = val_reg;
                val_next  = (val_reg == '0) ? IW'(cap_used - CW'(1)) :
                                              (val_reg - IW'(1));
                fill_next = fill_reg + IW'(1);
                fc_next   = cap_used;
                head_next = '0;
                tail_next = '0;
                rcnt_next = '0;
            end
            S_RCL_CMP:
            begin
                // head entry is due when now >= reuse time
                if (alu_carry)
                begin
                    st_we     = 1'b1;
                    st_waddr  = rt_id;
                    st_wdata  = ST_FREE;
                    fs_we     = 1'b1;
                    fs_waddr  = fc_reg[IW-1:0];
                    fs_wdata  = rt_id;
                    fc_next   = fc_reg + CW'(1);
                    head_next = (head_reg == ID_LAST) ? '0 : (head_reg + IW'(1));
                    rcnt_next = rcnt_reg - CW'(1);
                end
            end
            S_POP:
            begin
                res_grant_next = 1'b0;
                res_id_next    = '0;
                res_fault_next = 1'b0;
            end
            S_POP_WR:
            begin
                st_we          = 1'b1;
                st_waddr       = fs_rdata;
                st_wdata       = ST_PENDING;
                fc_next        = fc_reg - CW'(1);
                res_grant_next = 1'b1;
                res_id_next    = fs_rdata;
            end
            S_REL_RD:
            begin
                res_grant_next = 1'b0;
                res_id_next    = '0;
                res_fault_next = rel_oob;
            end
            S_REL_CHK:
            begin
                alu_op = ALU_ADD;
                alu_a  = UW'(now_reg);
                alu_b  = UW'(guard_reg);
                if (!rel_pending)
                begin
                    res_fault_next = 1'b1;
                end
                else if (!rel_retire)
                begin
                    st_we          = 1'b1;
                    st_waddr       = st_raddr;
                    st_wdata       = ST_FREE;
                    fs_we          = 1'b1;
                    fs_waddr       = fc_reg[IW-1:0];
                    fs_wdata       = st_raddr;
                    fc_next        = fc_reg + CW'(1);
                    res_grant_next = 1'b1;
                end
                else
                begin
                    st_we          = 1'b1;
                    st_waddr       = st_raddr;
                    st_wdata       = ST_RETIRED;
                    rt_we          = 1'b1;
                    tail_next      = (tail_reg == ID_LAST) ? '0 : (tail_reg + IW'(1));
                    rcnt_next      = rcnt_reg + CW'(1);
                    res_grant_next = 1'b1;
                end
            end
            S_OUT:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase

        if (geom_write)
        begin
            bit_next = BIT_W'(INIT_W - 1);
            rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_MOD;
            bit_reg       <= BIT_W'(INIT_W - 1);
            rem_reg       <= '0;
            fill_reg      <= '0;
            fc_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            init_reg      <= INIT_RESET;
            guard_reg     <= GUARD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            rem_reg   <= rem_next;
            fill_reg  <= fill_next;
            fc_reg    <= fc_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            rcnt_reg  <= rcnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CAPACITY: cap_reg   <= cfg_data[CAP_W-1:0];
                    CFG_INITIAL:  init_reg  <= cfg_data[INIT_W-1:0];
                    CFG_GUARD:    guard_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign res_id_ext = KW'(res_id_reg);

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        res_grant_reg <= res_grant_next;
        res_id_reg    <= res_id_next;
        res_fault_reg <= res_fault_next;
        if (in_fire)
        begin
            op_reg   <= op_t'(operation);
            now_reg  <= now_time;
            rel_reg  <= release_id_value;
            quar_reg <= quarantine;
        end
        if (out_load)
        begin
            out_grant_reg <= res_grant_reg;
            out_id_reg    <= res_id_ext[ID_PORT_W-1:0];
            out_fault_reg <= res_fault_reg && (op_reg == OP_RELEASE);
        end
    end

    assign out_valid  = out_valid_reg;
    assign granted    = out_grant_reg;
    assign granted_id = out_id_reg;
    assign fault      = out_fault_reg;

endmodule

FILE: dv/tb_transaction_id_pool_with_quarantine.sv
// testbench for transaction_id_pool_with_quarantine: directed and random allocate/release
// words checked against an in-bench pool predictor kept in a scoreboard class
// depends on tidp_pkg and the top level rtl
module tb_transaction_id_pool_with_quarantine
    import tidp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDS      = ID_SPACE_DEF;
    localparam int TBITS    = TIME_BITS_DEF;
    localparam logic [TBITS-1:0] TMAX = {TBITS{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LIMIT    = 1000000;
    localparam int PHASES   = 10;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        logic                 granted;
        logic [ID_PORT_W-1:0] id;
        logic                 fault;
    } grant_t;

    class id_pool_scoreboard;
        logic [CAP_W-1:0]   cap_reg;
        logic [INIT_W-1:0]  init_reg;
        logic [GUARD_W-1:0] guard_reg;
        id_status_t         status[IDS];
        logic [ID_PORT_W-1:0] free_ids[IDS];
        int                 free_n;
        logic [TBITS-1:0]   ret_time[IDS];
        logic [ID_PORT_W-1:0] ret_id[IDS];
        int                 ret_head;
        int                 ret_n;
        grant_t             expected_grants[$];
        int                 errors;

        function new();
            cap_reg   = CAP_RESET;
            init_reg  = INIT_RESET;
            guard_reg = GUARD_RESET;
            errors    = 0;
            rebuild();
        endfunction

        function int cap_eff();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > IDS)
                return IDS;
            return int'(cap_reg);
        endfunction

        function void rebuild();
            int cap;
            int first;
            cap   = cap_eff();
            first = int'(init_reg) % cap;
            for (int k = 0; k < IDS; k++)
                status[k] = (k < cap) ? ST_FREE : ST_UNAVAIL;
            for (int k = 0; k < cap; k++)
                free_ids[k] = ID_PORT_W'((first + cap - 1 - k) % cap);
            free_n   = cap;
            ret_head = 0;
            ret_n    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GUARD_W-1:0] v);
            if (idx == CFG_CAPACITY)
            begin
                cap_reg = v[CAP_W-1:0];
                rebuild();
            end
            else if (idx == CFG_INITIAL)
            begin
                init_reg = v[INIT_W-1:0];
                rebuild();
            end
            else if (idx == CFG_GUARD)
            begin
                guard_reg = v;
            end
        endfunction

        function void push_free(logic [ID_PORT_W-1:0] id);
            if (free_n < IDS)
            begin
                free_ids[free_n] = id;
                free_n++;
            end
        endfunction

        // random pending id below capacity, -1 when none
        function int pick_pending();
            int n;
            int sel;
            n = 0;
            for (int k = 0; k < cap_eff(); k++)
                if (status[k] == ST_PENDING)
                    n++;
            if (n == 0)
                return -1;
            sel = $urandom_range(0, n - 1);
            for (int k = 0; k < cap_eff(); k++)
                if (status[k] == ST_PENDING)
                begin
                    if (sel == 0)
                        return k;
                    sel--;
                end
            return -1;
        endfunction

        function void note_request(op_t op, logic [TBITS-1:0] t, logic [ID_PORT_W-1:0] rid,
                                   logic q);
            grant_t           exp;
            logic [ID_PORT_W-1:0] id;
            logic [TBITS:0]   sum;
            int               slot;
            exp = '0;
            if (op == OP_ALLOC)
            begin
                // return due ids in release order, stop at the first one not yet due
                while (ret_n > 0 && ret_time[ret_head] <= t)
                begin
                    id       = ret_id[ret_head];
                    ret_head = (ret_head + 1) % IDS;
                    ret_n--;
                    if (status[id] == ST_RETIRED)
                    begin
                        status[id] = ST_FREE;
                        push_free(id);
                    end
                end
                if (free_n > 0)
                begin
                    free_n--;
                    id = free_ids[free_n];
                    status[id] = ST_PENDING;
                    exp.granted = 1'b1;
                    exp.id = id;
                end
            end
            else
            begin
                if (int'(rid) >= cap_eff() || status[rid] != ST_PENDING)
                begin
                    exp.fault = 1'b1;
                end
                else if (!q || guard_reg == 0)
                begin
                    status[rid] = ST_FREE;
                    push_free(rid);
                    exp.granted = 1'b1;
                end
                else if (ret_n < IDS)
                begin
                    slot = (ret_head + ret_n) % IDS;
                    sum  = {1'b0, t} + {{(TBITS + 1 - GUARD_W){1'b0}}, guard_reg};
                    status[rid]    = ST_RETIRED;
                    ret_time[slot] = (sum > {1'b0, TMAX}) ? TMAX : sum[TBITS-1:0];
                    ret_id[slot]   = rid;
                    ret_n++;
                    exp.granted = 1'b1;
                end
            end
            expected_grants = {expected_grants, exp};
        endfunction

        task report_mismatch(string msg);
            if (errors < 100)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_grant(grant_t got);
            grant_t exp;
            if (expected_grants.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word granted=%0d id=%0d fault=%0d",
                                          got.granted, got.id, got.fault));
            end
            else
            begin
                exp = expected_grants.pop_front();
                if (got.granted !== exp.granted)
                    report_mismatch($sformatf("granted got %b want %b", got.granted,
                                              exp.granted));
                if (got.id !== exp.id)
                    report_mismatch($sformatf("granted_id got %0d want %0d", got.id, exp.id));
                if (got.fault !== exp.fault)
                    report_mismatch($sformatf("fault got %b want %b", got.fault, exp.fault));
            end
        endtask

        function int outstanding();
            return expected_grants.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GUARD_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = 1'b0;
    logic [TBITS-1:0]     now_time = '0;
    logic [ID_PORT_W-1:0] release_id_value = '0;
    logic                 quarantine = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 granted;
    logic [ID_PORT_W-1:0] granted_id;
    logic                 fault;

    id_pool_scoreboard sb = new();
    int  cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  rx_hold = 0;
    logic [TBITS-1:0] cur_time = '0;

    transaction_id_pool_with_quarantine dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .now_time         (now_time),
        .release_id_value (release_id_value),
        .quarantine       (quarantine),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .granted          (granted),
        .granted_id       (granted_id),
        .fault            (fault)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check every accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_grant('{granted: granted, id: granted_id, fault: fault});
    end

    function int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver stall pattern, at most one nonblocking update per edge
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
        end
        else if (rx_calm)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 35);
            rx_hold = pick_gap(1'b0);
        end
    end

    task send_word(op_t op, logic [TBITS-1:0] t, logic [ID_PORT_W-1:0] rid, logic q);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= op;
        now_time         <= t;
        release_id_value <= rid;
        quarantine       <= q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(op, t, rid, q);
    endtask

    task send_alloc(logic [TBITS-1:0] t);
        send_word(OP_ALLOC, t, ID_PORT_W'($urandom_range(0, IDS - 1)), 1'($urandom_range(0, 1)));
    endtask

    task drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [GUARD_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task setup_pool(logic [GUARD_W-1:0] guard, logic [CAP_W-1:0] cap, logic [INIT_W-1:0] init,
                    bit poke_unused);
        drain_results();
        write_cfg(CFG_GUARD, guard);
        write_cfg(CFG_CAPACITY, GUARD_W'(cap));
        write_cfg(CFG_INITIAL, GUARD_W'(init));
        if (poke_unused)
            write_cfg(CFG_UNUSED, $urandom);
        cfg_write <= 1'b0;
    endtask

    task advance_time(int guard_hint);
        logic [TBITS-1:0] step;
        if ($urandom_range(0, 99) < 5)
            step = TBITS'($urandom_range(0, 5000 + guard_hint));
        else
            step = TBITS'($urandom_range(0, 30));
        if (TMAX - cur_time < step)
            cur_time = TMAX;
        else
            cur_time = cur_time + step;
    endtask

    task random_word();
        int r;
        int pid;
        r = $urandom_range(0, 99);
        if (r < 85 && r >= 45)
            pid = sb.pick_pending();
        else
            pid = -1;
        if (r < 85 && pid >= 0)
            send_word(OP_RELEASE, cur_time, ID_PORT_W'(pid), 1'($urandom_range(0, 1)));
        else if (r < 85)
            send_alloc(cur_time);
        else
            // stray release, mostly ids that are not pending or out of range
            send_word(OP_RELEASE, cur_time, ID_PORT_W'($urandom_range(0, IDS - 1)),
                      1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [CAP_W-1:0]   cap;
        logic [INIT_W-1:0]  init;
        logic [GUARD_W-1:0] guard;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // default pool: zero guard frees at once, double release, release of a free id
        send_alloc(0);
        send_alloc(0);
        send_word(OP_RELEASE, 1, 0, 1'b1);
        send_word(OP_RELEASE, 2, 0, 1'b0);
        send_word(OP_RELEASE, 3, ID_PORT_W'(IDS - 1), 1'b1);

        // small pool with wrapped start and a guard
        setup_pool(100, 4, 6, 1'b0);
        repeat (5) send_alloc(5);
        send_word(OP_RELEASE, 10, 2, 1'b1);
        send_word(OP_RELEASE, 10, 3, 1'b0);
        send_word(OP_RELEASE, 20, 0, 1'b1);
        send_word(OP_RELEASE, 20, 5, 1'b0);
        send_word(OP_RELEASE, 20, 2, 1'b0);
        // head not yet due, then due
        send_alloc(50);
        send_alloc(50);
        send_alloc(115);
        // time going backwards
        send_alloc(30);
        send_alloc(200);
        // reuse time saturates at the largest time
        send_word(OP_RELEASE, TMAX - 50, 1, 1'b1);
        send_alloc(TMAX - 1);
        send_alloc(TMAX);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            init = INIT_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 20)
                guard = 0;
            else
                guard = $urandom_range(1, 300);
            if ($urandom_range(0, 99) < 75)
                cap = CAP_W'($urandom_range(2, 40));
            else
                cap = CAP_W'($urandom_range(41, 2047));
            case (ph)
                0:
                begin
                    cap = 2047;
                    init = 16'hFFFF;
                    guard = 32'hFFFF_FFFF;
                end
                1:
                begin
                    cap = 0;
                    init = 3;
                    guard = 0;
                end
                2:
                begin
                    cap = 1;
                    init = 0;
                end
                3:
                begin
                    cap = 1024;
                end
                default:
                begin
                end
            endcase
            setup_pool(guard, cap, init, ph == 4);
            tx_calm = (ph == 5) || ($urandom_range(0, 99) < 15);
            rx_calm = (ph == 5) || ($urandom_range(0, 99) < 15);
            if (ph % 3 == 0)
                cur_time = TBITS'({$urandom, $urandom});
            else
                cur_time = TBITS'($urandom_range(0, 1000));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off until everything outstanding has come back
                if (i == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.outstanding() > 0)
                        @(posedge clk);
                end
                advance_time((guard > 100000) ? 0 : int'(guard));
                random_word();
            end
        end

        in_valid <= 1'b0;
        rx_calm = 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
sv/tidp_pkg.sv
sv/tidp_ram.sv
sv/tidp_alu.sv
sv/transaction_id_pool_with_quarantine.sv
dv/tb_transaction_id_pool_with_quarantine.sv
